/* hw/rtl/quaternion_to_euler_bins_unit_macros.svh */
// assertion macros for the quaternion to euler bins unit
// used by the top level only, no other dependencies
`ifndef QUATERNION_TO_EULER_BINS_UNIT_MACROS_SVH
`define QUATERNION_TO_EULER_BINS_UNIT_MACROS_SVH

// same-cycle implication
`define QEB_ASSERT_IMPLIES(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("qeb assertion failed");

// next-cycle implication
`define QEB_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("qeb assertion failed");

`endif

/* hw/rtl/qeb_pkg.sv */
// shared types and constants for the quaternion to euler bins unit
// no dependencies
package qeb_pkg;

  localparam int CORDIC_W = 34;

  typedef logic signed [CORDIC_W-1:0] cordic_t;
  typedef logic signed [32:0] angle_t;

  // binary angle units, full turn is 2^32
  localparam angle_t ANG_PI      = 33'sd2147483648;
  localparam angle_t ANG_HALF_PI = 33'sd1073741824;

  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

  // atan(2^-i) in binary angle units
  function automatic cordic_t atan_entry(input logic [4:0] i);
    case (i)
      5'd0:  return 34'sd536870912;
      5'd1:  return 34'sd316933406;
      5'd2:  return 34'sd167458907;
      5'd3:  return 34'sd85004756;
      5'd4:  return 34'sd42667331;
      5'd5:  return 34'sd21354465;
      5'd6:  return 34'sd10679838;
      5'd7:  return 34'sd5340245;
      5'd8:  return 34'sd2670163;
      5'd9:  return 34'sd1335087;
      5'd10: return 34'sd667544;
      5'd11: return 34'sd333772;
      5'd12: return 34'sd166886;
      5'd13: return 34'sd83443;
      5'd14: return 34'sd41722;
      5'd15: return 34'sd20861;
      5'd16: return 34'sd10430;
      5'd17: return 34'sd5215;
      5'd18: return 34'sd2608;
      5'd19: return 34'sd1304;
      5'd20: return 34'sd652;
      5'd21: return 34'sd326;
      5'd22: return 34'sd163;
      5'd23: return 34'sd81;
      5'd24: return 34'sd41;
      5'd25: return 34'sd20;
      5'd26: return 34'sd10;
      5'd27: return 34'sd5;
      5'd28: return 34'sd3;
      5'd29: return 34'sd1;
      5'd30: return 34'sd1;
      default: return '0;
    endcase
  endfunction

endpackage

/* hw/rtl/qeb_atan2.sv */
// pipelined atan2: normalize shifts, sign fold, then one cordic vectoring step per stage
// depends on qeb_pkg
module qeb_atan2 import qeb_pkg::*; #(
  parameter int PW    = 34,
  parameter int STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pipe_ctl_t            ctl,
  input  logic signed [PW-1:0] y_in,
  input  logic signed [PW-1:0] x_in,
  input  logic                 force_in,
  input  angle_t               force_angle,
  output logic                 valid_out,
  output angle_t               angle
);

  localparam int RS = $clog2(PW - 28);
  localparam logic [PW-1:0] NORM_HI = {{(PW-31){1'b0}}, 1'b1, 30'b0};
  localparam cordic_t PI_C = CORDIC_W'(ANG_PI);

  function automatic logic [PW-1:0] mag_pw(input logic signed [PW-1:0] v);
    return v[PW-1] ? PW'(-v) : PW'(v);
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // right shift phase
  logic signed [PW-1:0] rx [RS+1];
  logic signed [PW-1:0] ry [RS+1];
  logic                 rv [RS+1];
  logic                 rsp [RS+1];
  angle_t               rang [RS+1];

  assign rx[0] = x_in;
  assign ry[0] = y_in;
  assign rv[0] = ctl.valid;

  // zero numerator and forced angle resolve up front
  always_comb begin
    rsp[0]  = 1'b0;
    rang[0] = '0;
    if (force_in) begin
      rsp[0]  = 1'b1;
      rang[0] = force_angle;
    end else if (y_in == '0) begin
      rsp[0]  = 1'b1;
      rang[0] = x_in[PW-1] ? ANG_PI : '0;
    end
  end

  for (genvar j = 0; j < RS; j++) begin : g_rshift
    localparam int B = 1 << (RS - 1 - j);
    logic signed [PW-1:0] tx, ty;
    logic big;
    assign tx  = rx[j] >>> (B - 1);
    assign ty  = ry[j] >>> (B - 1);
    assign big = (mag_pw(tx) >= NORM_HI) || (mag_pw(ty) >= NORM_HI);
    always_ff @(posedge clk) begin
      if (rst) begin
        rv[j+1] <= 1'b0;
      end else if (ctl.en) begin
        rv[j+1] <= rv[j];
      end
      if (ctl.en) begin
        rx[j+1]   <= big ? (rx[j] >>> B) : rx[j];
        ry[j+1]   <= big ? (ry[j] >>> B) : ry[j];
        rsp[j+1]  <= rsp[j];
        rang[j+1] <= rang[j];
      end
    end
  end

  // left shift phase, magnitude now below 2^30
  logic signed [31:0] lx [6];
  logic signed [31:0] ly [6];
  logic               lv [6];
  logic               lsp [6];
  angle_t             lang [6];

  assign lx[0]   = rx[RS][31:0];
  assign ly[0]   = ry[RS][31:0];
  assign lv[0]   = rv[RS];
  assign lsp[0]  = rsp[RS];
  assign lang[0] = rang[RS];

  for (genvar k = 0; k < 5; k++) begin : g_lshift
    localparam int B = 16 >> k;
    localparam logic [31:0] LIM = 32'd1 << (30 - B);
    logic fits;
    assign fits = (mag32(lx[k]) < LIM) && (mag32(ly[k]) < LIM);
    always_ff @(posedge clk) begin
      if (rst) begin
        lv[k+1] <= 1'b0;
      end else if (ctl.en) begin
        lv[k+1] <= lv[k];
      end
      if (ctl.en) begin
        lx[k+1]   <= fits ? (lx[k] <<< B) : lx[k];
        ly[k+1]   <= fits ? (ly[k] <<< B) : ly[k];
        lsp[k+1]  <= lsp[k];
        lang[k+1] <= lang[k];
      end
    end
  end

  // sign fold and cordic
  cordic_t cx [STEPS+1];
  cordic_t cy [STEPS+1];
  cordic_t cz [STEPS+1];
  logic    cv [STEPS+1];
  logic    csp [STEPS+1];
  angle_t  cang [STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (ctl.en) begin
      cv[0] <= lv[5];
    end
    if (ctl.en) begin
      if (lx[5][31]) begin
        cx[0] <= -CORDIC_W'(lx[5]);
        cy[0] <= -CORDIC_W'(ly[5]);
        cz[0] <= ly[5][31] ? -PI_C : PI_C;
      end else begin
        cx[0] <= CORDIC_W'(lx[5]);
        cy[0] <= CORDIC_W'(ly[5]);
        cz[0] <= '0;
      end
      csp[0]  <= lsp[5];
      cang[0] <= lang[5];
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_cordic
    cordic_t xs, ys;
    assign xs = cx[i] >>> i;
    assign ys = cy[i] >>> i;
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (ctl.en) begin
        cv[i+1] <= cv[i];
      end
      if (ctl.en) begin
        if (!cy[i][CORDIC_W-1]) begin
          cx[i+1] <= cx[i] + ys;
          cy[i+1] <= cy[i] - xs;
          cz[i+1] <= cz[i] + atan_entry(5'(i));
        end else begin
          cx[i+1] <= cx[i] - ys;
          cy[i+1] <= cy[i] + xs;
          cz[i+1] <= cz[i] - atan_entry(5'(i));
        end
        csp[i+1]  <= csp[i];
        cang[i+1] <= cang[i];
      end
    end
  end

  cordic_t zc;
  always_comb begin
    zc = cz[STEPS];
    if (zc > PI_C) zc = PI_C;
    if (zc < -PI_C) zc = -PI_C;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (ctl.en) begin
      valid_out <= cv[STEPS];
    end
    if (ctl.en) begin
      angle <= csp[STEPS] ? cang[STEPS] : 33'(zc);
    end
  end

  // cx[STEPS] and cy[STEPS] only feed nothing beyond the last step
  logic unused_tail;
  assign unused_tail = ^{cx[STEPS], cy[STEPS]};

endmodule

/* hw/rtl/quaternion_to_euler_bins_unit.sv */
// PW = max(2*QUAT_FRAC_BITS,32)+2; pipeline: products, sums, pitch rescale,
// sine square, square root, atan2, bins; one item per cycle unless stalled
// the 31-stage restoring square root for pitch and the cordic stages set the depth
// the whole pipe holds while a result waits and out_ready is low
// synchronous active-high reset clears all valid bits, payload is not reset
`include "quaternion_to_euler_bins_unit_macros.svh"
module quaternion_to_euler_bins_unit import qeb_pkg::*; #(
  parameter int ANGLE_BINS     = 18,
  parameter int QUAT_FRAC_BITS = 14,
  parameter int CORDIC_STEPS   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         roll_bin,
  output logic [4:0]         pitch_bin,
  output logic [4:0]         yaw_bin
);

  localparam int F2   = 2 * QUAT_FRAC_BITS;
  localparam int PW   = (F2 > 32) ? F2 + 2 : 34;
  localparam int SH_R = (F2 >= 30) ? F2 - 30 : 0;
  localparam int SH_L = (F2 >= 30) ? 0 : 30 - F2;
  localparam logic signed [PW-1:0] ONE = PW'(1) <<< F2;
  localparam logic [8:0] BINS_C = 9'(ANGLE_BINS);
  localparam int SQ = 31;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // products
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;
  logic v1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      p_wx <= quat_w * quat_x;
      p_yz <= quat_y * quat_z;
      p_xx <= quat_x * quat_x;
      p_yy <= quat_y * quat_y;
      p_wy <= quat_w * quat_y;
      p_zx <= quat_z * quat_x;
      p_wz <= quat_w * quat_z;
      p_xy <= quat_x * quat_y;
      p_zz <= quat_z * quat_z;
    end
  end

  // sums
  logic signed [PW-1:0] r_num, r_den, p_arg, y_num, y_den;
  logic v2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      r_num <= (PW'(p_wx) + PW'(p_yz)) <<< 1;
      r_den <= ONE - ((PW'(p_xx) + PW'(p_yy)) <<< 1);
      p_arg <= (PW'(p_wy) - PW'(p_zx)) <<< 1;
      y_num <= (PW'(p_wz) + PW'(p_xy)) <<< 1;
      y_den <= ONE - ((PW'(p_yy) + PW'(p_zz)) <<< 1);
    end
  end

  // pitch argument clamp and rescale so that one is 2^30
  logic signed [PW-1:0] p_c;
  always_comb begin
    p_c = p_arg;
    if (p_arg > ONE) p_c = ONE;
    if (p_arg < -ONE) p_c = -ONE;
  end

  logic signed [PW-1:0] rn3, rd3, yn3, yd3;
  logic signed [31:0]   sn3;
  logic v3;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      rn3 <= r_num;
      rd3 <= r_den;
      yn3 <= y_num;
      yd3 <= y_den;
      sn3 <= (F2 >= 30) ? 32'(p_c >>> SH_R) : 32'(p_c <<< SH_L);
    end
  end

  // square of the sine
  logic [30:0]          sn_mag;
  logic [61:0]          sq4;
  logic signed [PW-1:0] rn4, rd4, yn4, yd4;
  logic signed [31:0]   sn4;
  logic v4;
  assign sn_mag = sn3[31] ? 31'(-sn3) : sn3[30:0];
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      sq4 <= 62'(sn_mag) * 62'(sn_mag);
      rn4 <= rn3;
      rd4 <= rd3;
      yn4 <= yn3;
      yd4 <= yd3;
      sn4 <= sn3;
    end
  end

  // square root, one result bit per stage
  logic [61:0]          sv [SQ+1];
  logic [61:0]          sr [SQ+1];
  logic                 q_v [SQ+1];
  logic signed [PW-1:0] q_rn [SQ+1];
  logic signed [PW-1:0] q_rd [SQ+1];
  logic signed [PW-1:0] q_yn [SQ+1];
  logic signed [PW-1:0] q_yd [SQ+1];
  logic signed [31:0]   q_sn [SQ+1];

  assign sr[0] = '0;
  always_ff @(posedge clk) begin
    if (rst) begin
      q_v[0] <= 1'b0;
    end else if (en) begin
      q_v[0] <= v4;
    end
    if (en) begin
      sv[0]   <= (62'd1 << 60) - sq4;
      q_rn[0] <= rn4;
      q_rd[0] <= rd4;
      q_yn[0] <= yn4;
      q_yd[0] <= yd4;
      q_sn[0] <= sn4;
    end
  end

  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    localparam logic [61:0] B = 62'd1 << (2 * (SQ - 1 - j));
    logic [61:0] t;
    logic ge;
    assign t  = sr[j] + B;
    assign ge = sv[j] >= t;
    always_ff @(posedge clk) begin
      if (rst) begin
        q_v[j+1] <= 1'b0;
      end else if (en) begin
        q_v[j+1] <= q_v[j];
      end
      if (en) begin
        sv[j+1]   <= ge ? sv[j] - t : sv[j];
        sr[j+1]   <= ge ? (sr[j] >> 1) + B : sr[j] >> 1;
        q_rn[j+1] <= q_rn[j];
        q_rd[j+1] <= q_rd[j];
        q_yn[j+1] <= q_yn[j];
        q_yd[j+1] <= q_yd[j];
        q_sn[j+1] <= q_sn[j];
      end
    end
  end

  logic [30:0] cos_c;
  logic        cos_zero;
  angle_t      pitch_force;
  pipe_ctl_t   actl;
  assign cos_c       = sr[SQ][30:0];
  assign cos_zero    = (cos_c == '0);
  assign pitch_force = (q_sn[SQ] > 0) ? ANG_HALF_PI : -ANG_HALF_PI;
  assign actl        = '{en: en, valid: q_v[SQ]};

  logic   v_roll, v_pitch, v_yaw;
  angle_t a_roll, a_pitch, a_yaw;

  qeb_atan2 #(.PW(PW), .STEPS(CORDIC_STEPS)) u_roll (
    .clk(clk), .rst(rst), .ctl(actl),
    .y_in(q_rn[SQ]), .x_in(q_rd[SQ]),
    .force_in(1'b0), .force_angle('0),
    .valid_out(v_roll), .angle(a_roll)
  );

  qeb_atan2 #(.PW(PW), .STEPS(CORDIC_STEPS)) u_pitch (
    .clk(clk), .rst(rst), .ctl(actl),
    .y_in(PW'(q_sn[SQ])), .x_in(PW'($signed({1'b0, cos_c}))),
    .force_in(cos_zero), .force_angle(pitch_force),
    .valid_out(v_pitch), .angle(a_pitch)
  );

  qeb_atan2 #(.PW(PW), .STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .rst(rst), .ctl(actl),
    .y_in(q_yn[SQ]), .x_in(q_yd[SQ]),
    .force_in(1'b0), .force_angle('0),
    .valid_out(v_yaw), .angle(a_yaw)
  );

  // binning: offset to zero, scale by bin count, floor
  angle_t      ap_c;
  logic [32:0] u_roll_a, u_pitch_a, u_yaw_a;
  logic [41:0] m_roll, m_pitch, m_yaw;
  always_comb begin
    ap_c = a_pitch;
    if (a_pitch > ANG_HALF_PI) ap_c = ANG_HALF_PI;
    if (a_pitch < -ANG_HALF_PI) ap_c = -ANG_HALF_PI;
    u_roll_a  = a_roll + ANG_PI;
    u_pitch_a = ap_c + ANG_HALF_PI;
    u_yaw_a   = a_yaw + ANG_PI;
    m_roll    = 42'(u_roll_a) * 42'(BINS_C);
    m_pitch   = 42'(u_pitch_a) * 42'(BINS_C);
    m_yaw     = 42'(u_yaw_a) * 42'(BINS_C);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_roll;
    end
    if (en) begin
      roll_bin  <= m_roll[36:32];
      pitch_bin <= m_pitch[35:31];
      yaw_bin   <= m_yaw[36:32];
    end
  end

  `QEB_ASSERT_IMPLIES(a_lanes_aligned, clk, rst, 1'b1, (v_roll == v_pitch) && (v_roll == v_yaw))
  `QEB_ASSERT_IMPLIES(a_stall_only, clk, rst, !in_ready, out_valid && !out_ready)
  `QEB_ASSERT_NEXT(a_entry_valid, clk, rst, in_valid && in_ready, v1)
  `QEB_ASSERT_IMPLIES(a_sqrt_range, clk, rst, q_v[SQ], sr[SQ] <= (62'd1 << 30))
  `QEB_ASSERT_IMPLIES(a_bin_range, clk, rst, out_valid, (ANGLE_BINS > 31) || ((roll_bin <= BINS_C) && (pitch_bin <= BINS_C) && (yaw_bin <= BINS_C)))

endmodule

/* tb/sv/quaternion_to_euler_bins_unit_test.sv */
// testbench for the quaternion to euler bins unit: random and directed quaternions,
// bins predicted in fixed point and checked in order; depends on qeb_pkg and the rtl
module quaternion_to_euler_bins_unit_test;
  import qeb_pkg::*;

  localparam int NUM_BINS = 18;
  localparam int FRAC = 14;
  localparam int STEPS = 16;
  localparam int LATENCY = 63;
  localparam longint MAX_CYCLES = 400000;
  localparam longint BAM_PI = 64'sd2147483648;
  localparam longint BAM_HALF_PI = 64'sd1073741824;

  typedef struct packed {
    logic [4:0] roll;
    logic [4:0] pitch;
    logic [4:0] yaw;
  } euler_bins_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [4:0] roll_bin, pitch_bin, yaw_bin;

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  longint cycle = 0;
  int send_idle_pct = 29;
  int recv_idle_pct = 65;
  bit hold_off = 1'b0;

  quaternion_to_euler_bins_unit i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint abs_of(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint isqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // vectoring cordic, binary angle units
  function automatic longint cordic_atan2(longint y, longint x);
    longint ang, m, xs, ys;
    ang = 0;
    if (y == 0) return x < 0 ? BAM_PI : 0;
    m = abs_of(x) > abs_of(y) ? abs_of(x) : abs_of(y);
    while (m >= (64'sd1 << 30)) begin
      x = floor_shr(x, 1);
      y = floor_shr(y, 1);
      m = abs_of(x) > abs_of(y) ? abs_of(x) : abs_of(y);
    end
    while (m < (64'sd1 << 29)) begin
      x = x * 2;
      y = y * 2;
      m = m * 2;
    end
    if (x < 0) begin
      ang = (y >= 0) ? BAM_PI : -BAM_PI;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS && i < 32; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        ang = ang + longint'(atan_entry(5'(i)));
      end else begin
        x = x - ys;
        y = y + xs;
        ang = ang - longint'(atan_entry(5'(i)));
      end
    end
    if (ang > BAM_PI) ang = BAM_PI;
    if (ang < -BAM_PI) ang = -BAM_PI;
    return ang;
  endfunction

  function automatic longint pitch_angle(longint s, longint one);
    longint sn, c, a;
    if (s > one) s = one;
    if (s < -one) s = -one;
    sn = s * (64'sd1 << (30 - 2 * FRAC));
    c = isqrt((64'sd1 << 60) - sn * sn);
    if (c == 0) return sn > 0 ? BAM_HALF_PI : -BAM_HALF_PI;
    a = cordic_atan2(sn, c);
    if (a > BAM_HALF_PI) a = BAM_HALF_PI;
    if (a < -BAM_HALF_PI) a = -BAM_HALF_PI;
    return a;
  endfunction

  function automatic logic [4:0] angle_bin(longint ang, longint lower, int sh);
    longint u;
    u = ang + lower;
    return 5'((u * NUM_BINS) >> sh);
  endfunction

  function automatic euler_bins_t predict_bins(longint w, longint x, longint y, longint z);
    longint one;
    euler_bins_t b;
    one = 64'sd1 << (2 * FRAC);
    b.roll = angle_bin(cordic_atan2(2 * (w * x + y * z), one - 2 * (x * x + y * y)),
                       BAM_PI, 32);
    b.pitch = angle_bin(pitch_angle(2 * (w * y - z * x), one), BAM_HALF_PI, 31);
    b.yaw = angle_bin(cordic_atan2(2 * (w * z + x * y), one - 2 * (y * y + z * z)),
                      BAM_PI, 32);
    return b;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, field, got, want);
    errors++;
  endtask

  class euler_scoreboard;
    euler_bins_t pending[$];

    function void note_quat(logic signed [15:0] w, logic signed [15:0] x,
                            logic signed [15:0] y, logic signed [15:0] z);
      pending.push_back(predict_bins(w, x, y, z));
    endfunction

    task check_bins(logic [4:0] r, logic [4:0] p, logic [4:0] yw);
      euler_bins_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected item", 0, 0);
        return;
      end
      e = pending.pop_front();
      if (r !== e.roll) report_mismatch("roll_bin", r, e.roll);
      if (p !== e.pitch) report_mismatch("pitch_bin", p, e.pitch);
      if (yw !== e.yaw) report_mismatch("yaw_bin", yw, e.yaw);
    endtask
  endclass

  euler_scoreboard bins_board = new();

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycle);
      $display("tb: failure");
      $finish;
    end
  end

  // sample handshakes at the edge, before the driver nba updates land
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) bins_board.note_quat(quat_w, quat_x, quat_y, quat_z);
      if (out_valid && out_ready) begin
        bins_board.check_bins(roll_bin, pitch_bin, yaw_bin);
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // valid stays up after an accepted item so items can follow back to back
  task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    quat_w <= w;
    quat_x <= x;
    quat_y <= y;
    quat_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic signed [15:0] rand_comp();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  // roughly unit quaternion with random direction
  task automatic send_unit_quat();
    real a, b, c, d, n;
    a = $itor($signed($urandom_range(2000)) - 1000);
    b = $itor($signed($urandom_range(2000)) - 1000);
    c = $itor($signed($urandom_range(2000)) - 1000);
    d = $itor($signed($urandom_range(2000)) - 1000);
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0) begin
      a = 1.0;
      n = 1.0;
    end
    send_quat(16'($rtoi(16384.0 * a / n)), 16'($rtoi(16384.0 * b / n)),
              16'($rtoi(16384.0 * c / n)), 16'($rtoi(16384.0 * d / n)));
  endtask

  task automatic send_random(int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(9);
      if (k < 6) send_unit_quat();
      else if (k < 9) send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      else send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (bins_board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity, half turns about each axis, gimbal lock both ways
    send_quat(16384, 0, 0, 0);
    send_quat(-16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(11585, 0, 11585, 0);
    send_quat(11585, 0, -11585, 0);
    send_quat(11585, 11585, 0, 0);
    send_quat(11585, 0, 0, -11585);
    send_quat(0, 0, 0, 0);
    send_quat(16384, 16384, 16384, 16384);
    send_quat(-16384, -16384, -16384, -16384);
    send_quat(16384, -16384, 16384, -16384);
    send_quat(-32768, 32767, -32768, 32767);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_quat(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    send_quat(8192, 8192, 8192, 8192);
    send_quat(1, -1, 1, -1);

    send_random(330);

    // long receiver stall while the sender keeps offering items
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      send_random(120);
    join
    drain();

    send_idle_pct = 65;
    recv_idle_pct = 29;
    send_random(300);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(300);

    drain();
    repeat (LATENCY + 10) @(posedge clk);
    $display("sent %0d quaternions, checked %0d bin triples, including stalls and",
             items_sent, results_seen);
    $display("directed extremes such as gimbal lock, zero and out-of-range inputs");
    if (errors == 0 && bins_board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
